/* src/kmd_pkg.sv */
// shared constants and types for the keypad matrix debouncer
package kmd_pkg;

    // field widths
    localparam int CMD_W  = 2;
    localparam int ROW_W  = 2;
    localparam int COL_W  = 3;
    localparam int KEY_W  = 4;
    localparam int CNT_W  = 7;
    localparam int PHASE_W = 2;

    // stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = CMD_W + ROW_W + COL_W + KEY_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + COL_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CNT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

    localparam logic [CNT_W-1:0] MAX_COUNT_RST = 7'd64;
    localparam logic [CNT_W-1:0] THRESHOLD_RST = 7'd32;

    // default geometry
    localparam int NUM_KEYS_DEF = 12;
    localparam int NUM_ROWS_DEF = 4;
    localparam int NUM_COLS_DEF = 3;

    // commands
    localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LEVEL = 2'd2;

    // key phases
    localparam logic [PHASE_W-1:0] PHASE_UP      = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_DOWN    = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_PRESSED = 2'd2;

    // per-key control, already qualified by the pipeline advancing
    typedef struct packed {
        logic scan;    // this key's row is being scanned
        logic closed;  // raw column level of this key
        logic take;    // take command addressed to this key
    } cell_ctrl_t;

    typedef struct packed {
        logic level;       // debounced level from the stored counter
        logic level_next;  // debounced level after a scan update
        logic pressed;     // phase is pressed
    } cell_stat_t;

endpackage

/* src/kmd_key_cell.sv */
// one key: integrating counter and press phase
module kmd_key_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [kmd_pkg::CNT_W-1:0] max_count,
    input  logic [kmd_pkg::CNT_W-1:0] press_threshold,
    input  kmd_pkg::cell_ctrl_t       ctrl,
    output kmd_pkg::cell_stat_t       stat
);
    import kmd_pkg::*;

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   cnt_upd;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               lvl_upd;

    always_comb
    begin
        cnt_upd = cnt_reg;
        if (ctrl.closed)
        begin
            if (cnt_reg < max_count)
                cnt_upd = cnt_reg + 1'b1;
        end
        else if (cnt_reg != '0)
        begin
            cnt_upd = cnt_reg - 1'b1;
        end
        lvl_upd = (cnt_upd >= press_threshold);

        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        if (ctrl.scan)
        begin
            cnt_next = cnt_upd;
            if (lvl_upd)
            begin
                if (phase_reg == PHASE_UP)
                    phase_next = PHASE_DOWN;
            end
            else if (phase_reg == PHASE_DOWN)
            begin
                phase_next = PHASE_PRESSED;
            end
        end
        else if (ctrl.take && phase_reg == PHASE_PRESSED)
        begin
            phase_next = PHASE_UP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= PHASE_UP;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    assign stat.level      = (cnt_reg >= press_threshold);
    assign stat.level_next = lvl_upd;
    assign stat.pressed    = (phase_reg == PHASE_PRESSED);

endmodule

/* src/keypad_matrix_debouncer.sv */
// keypad matrix debouncer top level: stream ports, pipeline and key cells
//
//  port group        | dir | contents
//  s_tvalid/tready   | in  | s_tdata: cmd[1:0] row_number[3:2] column_levels[6:4] key_number[10:7]
//  m_tvalid/tready   | out | m_tdata: answer_flag[0] row_held_levels[3:1]
//  cfg_we/index/data | in  | 0 max_count, 1 press_threshold
//
// one item per cycle sustained while the output is not back-pressured: an input register,
// then the key cells and result register update together. the key state is read from the
// cells the cycle it is written back, so items follow back to back. the input side keeps
// taking items while a result waits, up to one held item. after reset all counters are
// zero and all keys up.
module keypad_matrix_debouncer #(
    parameter int NUM_KEYS = kmd_pkg::NUM_KEYS_DEF,
    parameter int NUM_ROWS = kmd_pkg::NUM_ROWS_DEF,
    parameter int NUM_COLS = kmd_pkg::NUM_COLS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cmd, row_number, column_levels, key_number (from bit 0 up)
    input  logic [kmd_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // answer_flag, row_held_levels (from bit 0 up)
    output logic [kmd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_we,
    input  logic [kmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kmd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kmd_pkg::*;

    logic [CNT_W-1:0] max_count_reg;
    logic [CNT_W-1:0] threshold_reg;

    logic             in_valid_reg;
    logic [CMD_W-1:0] in_cmd_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [COL_W-1:0] in_cols_reg;
    logic [KEY_W-1:0] in_key_reg;

    logic             out_valid_reg;
    logic             out_flag_reg;
    logic [COL_W-1:0] out_levels_reg;

    logic             advance;
    logic             in_take;
    logic             is_scan;
    logic             is_take;
    logic             is_level;
    logic             flag_next;
    logic [COL_W-1:0] levels_next;

    cell_ctrl_t       ctrl [NUM_KEYS];
    cell_stat_t       stat [NUM_KEYS];
    logic [COL_W-1:0] row_lvl [NUM_KEYS];
    logic [NUM_KEYS-1:0] key_flag;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign is_scan  = (in_cmd_reg == CMD_SCAN);
    assign is_take  = (in_cmd_reg == CMD_TAKE);
    assign is_level = (in_cmd_reg == CMD_LEVEL);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg <= MAX_COUNT_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_COUNT: max_count_reg <= cfg_data;
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // key cells, each tied to its fixed row and column
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        localparam int ROW = k / NUM_COLS;
        localparam int COL = k % NUM_COLS;
        logic closed_bit;
        logic row_hit;
        logic key_hit;

        if (COL < COL_W)
        begin : g_col
            assign closed_bit = in_cols_reg[COL];
            assign row_lvl[k] = COL_W'(row_hit && stat[k].level_next) << COL;
        end
        else
        begin : g_nocol
            assign closed_bit = 1'b0;
            assign row_lvl[k] = '0;
        end

        if (ROW < NUM_ROWS && ROW < (1 << ROW_W))
        begin : g_row
            assign row_hit = (in_row_reg == ROW_W'(ROW));
        end
        else
        begin : g_norow
            assign row_hit = 1'b0;
        end

        if (k < (1 << KEY_W))
        begin : g_sel
            assign key_hit = (in_key_reg == KEY_W'(k));
        end
        else
        begin : g_nosel
            assign key_hit = 1'b0;
        end

        assign ctrl[k].scan   = advance && is_scan && row_hit;
        assign ctrl[k].closed = closed_bit;
        assign ctrl[k].take   = advance && is_take && key_hit;
        assign key_flag[k]    = key_hit && ((is_take && stat[k].pressed) ||
                                            (is_level && stat[k].level));

        kmd_key_cell u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .max_count       (max_count_reg),
            .press_threshold (threshold_reg),
            .ctrl            (ctrl[k]),
            .stat            (stat[k])
        );
    end

    always_comb
    begin
        levels_next = '0;
        for (int k = 0; k < NUM_KEYS; k++)
            levels_next = levels_next | row_lvl[k];
        if (!is_scan)
            levels_next = '0;
        flag_next = |key_flag;
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= s_tdata[CMD_W-1:0];
            in_row_reg  <= s_tdata[CMD_W +: ROW_W];
            in_cols_reg <= s_tdata[CMD_W+ROW_W +: COL_W];
            in_key_reg  <= s_tdata[CMD_W+ROW_W+COL_W +: KEY_W];
        end
        if (advance)
        begin
            out_flag_reg   <= flag_next;
            out_levels_reg <= levels_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, out_levels_reg, out_flag_reg};

    // a held input item always moves on once the result register is free
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("held item did not reach the result register");

    // the input side only stalls while an item is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
        else $error("input stalled with no held item");

    // a flag answer never carries row levels
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_flag_reg |-> out_levels_reg == '0)
        else $error("flag and row levels set together");

    // a register write lands on the next edge
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == CFG_THRESHOLD |=> threshold_reg == $past(cfg_data))
        else $error("threshold write lost");

endmodule

/* test/keypad_matrix_debouncer_tb.sv */
// self-checking testbench for the keypad matrix debouncer: random stream traffic and stalls
module keypad_matrix_debouncer_tb;
    import kmd_pkg::*;

    localparam int KEYS        = NUM_KEYS_DEF;
    localparam int ROWS        = NUM_ROWS_DEF;
    localparam int COLS        = NUM_COLS_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 80;
    localparam int PRINT_CAP   = 100;
    localparam int NUM_PHASES  = 8;

    localparam logic [CMD_W-1:0]     CMD_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

    typedef struct packed {
        logic [3:0]       gap;
        logic [KEY_W-1:0] key;
        logic [COL_W-1:0] cols;
        logic [ROW_W-1:0] row;
        logic [CMD_W-1:0] cmd;
    } key_item_t;

    typedef struct packed {
        logic             flag;
        logic [COL_W-1:0] levels;
    } key_answer_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state
    logic [CNT_W-1:0]   key_count [KEYS];
    logic [PHASE_W-1:0] key_phase [KEYS];
    logic [CNT_W-1:0]   max_count_cfg;
    logic [CNT_W-1:0]   threshold_cfg;

    key_item_t   pending_items [$];
    key_answer_t expected_answers [$];
    key_item_t   offered;
    key_answer_t predicted;
    key_answer_t want;

    int  items_queued   = 0;
    int  items_accepted = 0;
    int  results_seen   = 0;
    int  mismatches     = 0;
    int  gap_count      = 0;
    int  ready_wait     = 0;
    int  quiet_cycles   = 0;
    int  cycle_cnt      = 0;
    bit  fast_gaps      = 1'b0;

    int phase_max [NUM_PHASES] = '{5, 127, 20, 1, 127, 10, 64, 3};
    int phase_thr [NUM_PHASES] = '{3, 100, 10, 1, 0, 127, 32, 2};
    int phase_len [NUM_PHASES] = '{180, 300, 180, 150, 150, 150, 250, 150};

    keypad_matrix_debouncer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at result %0d: %s got %0d want %0d",
                     results_seen, what, got, exp_val);
    endtask

    task automatic clear_keys();
        int k;
        for (k = 0; k < KEYS; k++)
        begin
            key_count[k] = '0;
            key_phase[k] = PHASE_UP;
        end
        max_count_cfg = MAX_COUNT_RST;
        threshold_cfg = THRESHOLD_RST;
    endtask

    task automatic debounce_step(input key_item_t it, output key_answer_t ans);
        int c;
        int k;
        ans = '0;
        if (it.cmd == CMD_SCAN)
        begin
            if (it.row < ROWS)
            begin
                for (c = 0; c < COLS; c++)
                begin
                    k = it.row * COLS + c;
                    if (k < KEYS)
                    begin
                        if (it.cols[c])
                        begin
                            if (key_count[k] < max_count_cfg)
                                key_count[k] = key_count[k] + 1'b1;
                        end
                        else if (key_count[k] != 0)
                        begin
                            key_count[k] = key_count[k] - 1'b1;
                        end
                        if (key_count[k] >= threshold_cfg)
                        begin
                            ans.levels[c] = 1'b1;
                            if (key_phase[k] == PHASE_UP)
                                key_phase[k] = PHASE_DOWN;
                        end
                        else if (key_phase[k] == PHASE_DOWN)
                        begin
                            key_phase[k] = PHASE_PRESSED;
                        end
                    end
                end
            end
        end
        else if (it.cmd == CMD_TAKE)
        begin
            if (it.key < KEYS && key_phase[it.key] == PHASE_PRESSED)
            begin
                key_phase[it.key] = PHASE_UP;
                ans.flag = 1'b1;
            end
        end
        else if (it.cmd == CMD_LEVEL)
        begin
            if (it.key < KEYS && key_count[it.key] >= threshold_cfg)
                ans.flag = 1'b1;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_MAX_COUNT)
            max_count_cfg = value[CNT_W-1:0];
        else if (idx == CFG_THRESHOLD)
            threshold_cfg = value[CNT_W-1:0];
        @(negedge clk);
    endtask

    task automatic add_item(input logic [CMD_W-1:0] cmd, input int row, input int cols,
                            input int key);
        key_item_t it;
        it.cmd  = cmd;
        it.row  = row[ROW_W-1:0];
        it.cols = cols[COL_W-1:0];
        it.key  = key[KEY_W-1:0];
        it.gap  = fast_gaps ? 4'd0 : 4'($urandom_range(0, 10));
        pending_items.push_back(it);
        items_queued++;
    endtask

    // wait until every queued item went in and every result came out
    task automatic wait_idle();
        while (items_accepted != items_queued || expected_answers.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // hold a column pattern on one row for a random number of scans, release, take
    task automatic press_sequence(input int burst_lim);
        int row;
        int mask;
        int n;
        int i;
        int c;
        row  = $urandom_range(0, ROWS - 1);
        mask = $urandom_range(1, 7);
        n    = $urandom_range(1, burst_lim);
        for (i = 0; i < n; i++)
        begin
            add_item(CMD_SCAN, row, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : mask, 0);
            if ($urandom_range(0, 7) == 0)
                add_item(CMD_LEVEL, 0, 0, row * COLS + $urandom_range(0, COLS - 1));
        end
        n = $urandom_range(1, burst_lim);
        for (i = 0; i < n; i++)
            add_item(CMD_SCAN, row, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 0, 0);
        for (c = 0; c < COLS; c++)
        begin
            if (mask[c])
            begin
                add_item(CMD_TAKE, 0, 0, row * COLS + c);
                if ($urandom_range(0, 3) == 0)
                    add_item(CMD_TAKE, 0, 0, row * COLS + c);
            end
        end
    endtask

    task automatic random_phase(input int max_val, input int thr_val, input int n_items);
        int start;
        int burst_lim;
        write_reg(CFG_MAX_COUNT, max_val);
        write_reg(CFG_THRESHOLD, thr_val);
        burst_lim = ((thr_val < 4) ? 4 : thr_val) + 4;
        if (burst_lim > 120)
            burst_lim = 120;
        start = items_queued;
        while (items_queued - start < n_items)
        begin
            fast_gaps = (items_queued - start) < 40;
            if ($urandom_range(0, 4) == 0)
                add_item(2'($urandom_range(0, 3)), $urandom_range(0, 3),
                         $urandom_range(0, 7), $urandom_range(0, 15));
            else
                press_sequence(burst_lim);
        end
        wait_idle();
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            gap_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                debounce_step(offered, predicted);
                expected_answers.push_back(predicted);
                items_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && gap_count >= pending_items[0].gap)
                begin
                    offered   = pending_items.pop_front();
                    gap_count = 0;
                    s_tvalid  <= 1'b1;
                    s_tdata   <= IN_DATA_W'({offered.key, offered.cols, offered.row, offered.cmd});
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    if (pending_items.size() != 0)
                        gap_count++;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_answers.size() == 0)
                begin
                    report_mismatch("result with nothing pending, tdata", m_tdata, 0);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (m_tdata[0] !== want.flag)
                        report_mismatch("answer_flag", m_tdata[0], want.flag);
                    if (m_tdata[3:1] !== want.levels)
                        report_mismatch("row_held_levels", m_tdata[3:1], want.levels);
                end
                ready_wait = (cycle_cnt % 256 < 64) ? 0 : $urandom_range(0, 10);
                // long back-pressure so the input side fills and stalls
                if (results_seen == 300 || results_seen == 900)
                    ready_wait = LONG_HOLD;
            end
            if (ready_wait != 0)
            begin
                ready_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on transfers
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("keypad_matrix_debouncer_tb failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int p;
        clear_keys();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: counters far below threshold
        add_item(CMD_SCAN, 0, 7, 0);
        add_item(CMD_SCAN, 3, 0, 0);
        add_item(CMD_SCAN, 3, 7, 0);
        add_item(CMD_LEVEL, 0, 0, 0);
        add_item(CMD_LEVEL, 0, 0, 11);
        add_item(CMD_LEVEL, 0, 0, 15);
        add_item(CMD_TAKE, 0, 0, 0);
        add_item(CMD_TAKE, 0, 0, 12);
        add_item(CMD_UNUSED, 3, 7, 15);
        add_item(CMD_UNUSED, 0, 0, 0);
        wait_idle();

        // tiny window: full press, take twice, out of range keys
        write_reg(CFG_MAX_COUNT, 2);
        write_reg(CFG_THRESHOLD, 2);
        write_reg(CFG_UNUSED_LO, 127);
        write_reg(CFG_UNUSED_HI, 0);
        add_item(CMD_SCAN, 0, 7, 0);
        add_item(CMD_SCAN, 0, 7, 0);
        add_item(CMD_LEVEL, 0, 0, 2);
        add_item(CMD_SCAN, 0, 0, 0);
        add_item(CMD_TAKE, 0, 0, 0);
        add_item(CMD_TAKE, 0, 0, 0);
        add_item(CMD_TAKE, 0, 0, 1);
        add_item(CMD_SCAN, 1, 5, 0);
        add_item(CMD_SCAN, 2, 2, 0);
        add_item(CMD_LEVEL, 0, 0, 13);
        add_item(CMD_TAKE, 0, 0, 15);
        add_item(CMD_SCAN, 3, 7, 0);
        add_item(CMD_SCAN, 3, 7, 0);
        add_item(CMD_LEVEL, 0, 0, 9);
        wait_idle();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 3)
            begin
                write_reg(CFG_UNUSED_LO, $urandom_range(0, 127));
                write_reg(CFG_UNUSED_HI, $urandom_range(0, 127));
            end
            random_phase(phase_max[p], phase_thr[p], phase_len[p]);
        end

        if (mismatches == 0)
            $display("keypad_matrix_debouncer_tb passed");
        else
            $display("keypad_matrix_debouncer_tb failed");
        $finish;
    end

endmodule
